FILE: rtl/descriptor_index_allocator_defines.svh
// Assertion macros shared by the descriptor index allocator RTL.
// Depends on nothing; included by the top level only.
`ifndef DESCRIPTOR_INDEX_ALLOCATOR_DEFINES_SVH
`define DESCRIPTOR_INDEX_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DIA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dia_pkg.sv
// Shared types and constants for the descriptor index allocator.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package dia_pkg;

   // Field and port widths.
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int SLOT_W      = 7;
   localparam int MAX_COUNT_W = 8;
   localparam int HANDLE_W    = 16;
   localparam int ADDR_W      = 64;
   localparam int STATUS_W    = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_MAX_COUNT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HANDLE_SIZE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CPU_BASE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GPU_BASE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

   // Register reset values.
   localparam logic [MAX_COUNT_W-1:0] MAX_COUNT_RST = 8'd128;
   localparam logic [HANDLE_W-1:0]    HANDLE_RST    = 16'd32;

   // Request action code for a free.
   localparam logic ACT_FREE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREE_REJECTED = 2'd2;

   typedef struct packed {
      logic              action;
      logic [SLOT_W-1:0] free_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_index;
      logic [ADDR_W-1:0]   cpu_address;
      logic [ADDR_W-1:0]   gpu_address;
      logic                gpu_valid;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [MAX_COUNT_W-1:0] max_count;
      logic [HANDLE_W-1:0]    handle_size;
      logic [ADDR_W-1:0]      cpu_base;
      logic [ADDR_W-1:0]      gpu_base;
      logic                   shader_visible;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic mul_en;
      logic load;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_full;
   } ctl_sts_type;

endpackage

FILE: rtl/dia_csr.sv
// Configuration registers of the descriptor index allocator.
// Depends on dia_pkg.
`timescale 1ns / 1ps

module dia_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dia_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dia_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output dia_pkg::cfg_type                    cfg
);

   dia_pkg::cfg_type cfg_ff;
   dia_pkg::cfg_type cfg_in;

   // Decode a write; each register keeps only its low bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dia_pkg::REG_MAX_COUNT: begin
               cfg_in.max_count = csr_wdata[dia_pkg::MAX_COUNT_W-1:0];
            end
            dia_pkg::REG_HANDLE_SIZE: begin
               cfg_in.handle_size = csr_wdata[dia_pkg::HANDLE_W-1:0];
            end
            dia_pkg::REG_CPU_BASE: begin
               cfg_in.cpu_base = csr_wdata[dia_pkg::ADDR_W-1:0];
            end
            dia_pkg::REG_GPU_BASE: begin
               cfg_in.gpu_base = csr_wdata[dia_pkg::ADDR_W-1:0];
            end
            dia_pkg::REG_SHADER_VISIBLE: begin
               cfg_in.shader_visible = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_count      <= dia_pkg::MAX_COUNT_RST;
         cfg_ff.handle_size    <= dia_pkg::HANDLE_RST;
         cfg_ff.cpu_base       <= '0;
         cfg_ff.gpu_base       <= '0;
         cfg_ff.shader_visible <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/dia_ctrl.sv
// Controller state machine of the descriptor index allocator.
// Depends on dia_pkg; drives the datapath through ctl_cmd_type.
`timescale 1ns / 1ps

module dia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   input  dia_pkg::ctl_sts_type  sts,
   output dia_pkg::ctl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       out_free;

   // The output register can take a result when empty or being drained.
   assign out_free = !sts.out_full || rsp_ready;

   // Sequence one request through lookup, multiply and address sum.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.load = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

FILE: rtl/dia_dp.sv
// Datapath of the descriptor index allocator: free-list queue, fresh
// counter, offset multiplier, address adders and output register. Depends on dia_pkg.
`timescale 1ns / 1ps

module dia_dp #(
   parameter int CAPACITY = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dia_pkg::cfg_type      cfg,
   input  dia_pkg::req_type      req_data,
   input  dia_pkg::ctl_cmd_type  cmd,
   output dia_pkg::ctl_sts_type  sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dia_pkg::rsp_type      rsp_data
);

   localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int LW    = (CW > dia_pkg::MAX_COUNT_W) ? CW : dia_pkg::MAX_COUNT_W;
   localparam int SW    = (CW > dia_pkg::SLOT_W) ? CW : dia_pkg::SLOT_W;
   localparam int PRODW = dia_pkg::HANDLE_W + SW;
   localparam logic [PW-1:0] LAST_POS   = PW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
   localparam logic [LW-1:0] CAP_LIMIT  = LW'(CAPACITY);

   // Free-list storage; an entry's value is used only after being written.
   logic [dia_pkg::SLOT_W-1:0] free_list [CAPACITY];

   logic [PW-1:0]                head_ff, head_in;
   logic [PW-1:0]                tail_ff, tail_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                fresh_ff, fresh_in;
   logic [dia_pkg::SLOT_W-1:0]   list_rd_ff;
   logic [SW-1:0]                fresh_slot_ff;
   logic                         from_list_ff;
   logic                         ok_ff;
   logic [dia_pkg::STATUS_W-1:0] status_ff;
   logic [dia_pkg::STATUS_W-1:0] status_in;
   logic [SW-1:0]                slot_ff;
   logic [PRODW-1:0]             prod_ff;
   logic                         rsp_valid_ff;
   dia_pkg::rsp_type             rsp_data_ff;
   dia_pkg::rsp_type             rsp_next;

   logic [LW-1:0]             limit;
   logic                      is_free;
   logic                      free_ok;
   logic                      have_list;
   logic                      have_fresh;
   logic                      list_push;
   logic                      list_pop;
   logic                      fresh_take;
   logic [SW-1:0]             slot_sel;
   logic [dia_pkg::ADDR_W-1:0] offset;

   // Request decode against the current queue state.
   always_comb begin
      limit = (LW'(cfg.max_count) > CAP_LIMIT) ? CAP_LIMIT : LW'(cfg.max_count);
      is_free    = (req_data.action == dia_pkg::ACT_FREE);
      free_ok    = (LW'(req_data.free_index) < limit) && (count_ff < FULL_COUNT);
      have_list  = (count_ff != '0);
      have_fresh = (LW'(fresh_ff) < limit);
      list_push  = cmd.accept && is_free && free_ok;
      list_pop   = cmd.accept && !is_free && have_list;
      fresh_take = cmd.accept && !is_free && !have_list && have_fresh;
   end

   // Next values of the queue pointers, fill count and fresh counter.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      if (list_pop) begin
         head_in  = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (list_push) begin
         tail_in  = (tail_ff == LAST_POS) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (fresh_take) begin
         fresh_in = fresh_ff + 1'b1;
      end
   end

   // Result status decided at acceptance.
   always_comb begin
      if (is_free) begin
         status_in = free_ok ? dia_pkg::STATUS_OK : dia_pkg::STATUS_FREE_REJECTED;
      end else begin
         status_in = (have_list || have_fresh) ? dia_pkg::STATUS_OK
                                               : dia_pkg::STATUS_EXHAUSTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         fresh_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
   end

   // Free-list memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (list_push) begin
         free_list[tail_ff] <= req_data.free_index;
      end
      if (cmd.accept) begin
         list_rd_ff <= free_list[head_ff];
      end
   end

   // Capture the request outcome at acceptance.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         from_list_ff  <= have_list;
         fresh_slot_ff <= SW'(fresh_ff);
         ok_ff         <= !is_free && (have_list || have_fresh);
         status_ff     <= status_in;
      end
   end

   // Offset multiply: handle size times the chosen slot.
   assign slot_sel = from_list_ff ? SW'(list_rd_ff) : fresh_slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         slot_ff <= slot_sel;
         prod_ff <= PRODW'(cfg.handle_size) * PRODW'(slot_sel);
      end
   end

   // Address sums; failed and free requests report zero fields.
   assign offset = dia_pkg::ADDR_W'(prod_ff);

   always_comb begin
      rsp_next        = '0;
      rsp_next.status = status_ff;
      if (ok_ff) begin
         rsp_next.slot_index  = slot_ff[dia_pkg::SLOT_W-1:0];
         rsp_next.cpu_address = cfg.cpu_base + offset;
         if (cfg.shader_visible) begin
            rsp_next.gpu_address = cfg.gpu_base + offset;
            rsp_next.gpu_valid   = 1'b1;
         end
      end
   end

   // Output register holds a result until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign sts.out_full = rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

FILE: rtl/descriptor_index_allocator.sv
// Channel   Ports                                  Direction
// req       req_valid, req_ready, req_data         in: allocate or free request
// rsp       rsp_valid, rsp_ready, rsp_data         out: one result per request
// csr       csr_wr_en, csr_index, csr_wdata        in: register writes
//
// Each request passes three steps: accept with the free-list read, the
// handle-size multiply, then the 64-bit address sums into the output register.
// The controller takes no new request until the last one has loaded its result.
// A held result does not block acceptance; the sum step waits only while the
// output register is full and not being drained. Reset is synchronous and needs
// no clearing pass: a free-list entry is used only after being written.
// Top level of the descriptor index allocator; depends on dia_pkg, dia_csr,
// dia_ctrl, dia_dp and descriptor_index_allocator_defines.svh.
`timescale 1ns / 1ps
`include "descriptor_index_allocator_defines.svh"

module descriptor_index_allocator #(
   parameter int CAPACITY = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dia_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dia_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [dia_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dia_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dia_pkg::cfg_type     cfg;
   dia_pkg::ctl_cmd_type cmd;
   dia_pkg::ctl_sts_type sts;

   dia_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dia_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A transfer in starts the multiply step and blocks further requests.
   `DIA_ASSERT_NEXT(a_accept_starts_mul, clock, reset, req_valid && req_ready, !req_ready && cmd.mul_en, "request transfer not followed by multiply step")
   // A result is never loaded over one that still waits.
   `DIA_ASSERT_SAME(a_load_no_overwrite, clock, reset, cmd.load, !rsp_valid || rsp_ready, "result loaded over pending result")
   // The multiply step is always followed by the sum step.
   `DIA_ASSERT_NEXT(a_mul_then_sum, clock, reset, cmd.mul_en, !req_ready && !cmd.mul_en, "multiply step not followed by sum step")
   // A loaded result is offered in the next cycle.
   `DIA_ASSERT_NEXT(a_load_offers, clock, reset, cmd.load, rsp_valid, "loaded result not offered")

endmodule
